// ===== hw/rtl/nlq_pkg.sv =====
// Shared types and constants for the newline line queue.
package nlq_pkg;

  localparam int unsigned QueueLines = 64;
  localparam int unsigned LineMax    = 256;

  localparam logic [7:0] NewlineByte = 8'd10;

  localparam logic [1:0] CmdRecv  = 2'd0;
  localparam logic [1:0] CmdFetch = 2'd1;
  localparam logic [1:0] CmdClear = 2'd2;
  localparam logic [1:0] CmdFlush = 2'd3;

  localparam logic [1:0] StNone  = 2'd0;
  localparam logic [1:0] StData  = 2'd1;
  localparam logic [1:0] StEmpty = 2'd2;

  localparam logic [8:0] ReadLimitReset = 9'd257;

  // Classified operation handed from front to back.
  typedef enum logic [2:0] {
    OpByte,
    OpEol,
    OpOverrun,
    OpFetch,
    OpClear,
    OpFlush
  } op_e;

  typedef struct packed {
    op_e        op;
    logic [7:0] data;
  } op_t;

endpackage

// ===== hw/rtl/newline_line_queue_unit.sv =====
// Top level of the newline line queue: register port, front end, back end.
// Bytes and commands are taken one per cycle while the two-entry queue has room;
// received bytes, clears and flushes retire on acceptance in the back end,
// while a fetch with lines queued passes through accept, registered memory read
// and result build, then waits for its result to be taken; the back end takes nothing
// else meanwhile. Lines are never copied: the ring has one spare slot in which
// the partial line is built, so a completed line only moves the ring pointers.
// No clearing pass.
module newline_line_queue_unit #(
  parameter int unsigned QUEUE_LINES = nlq_pkg::QueueLines,
  parameter int unsigned LINE_MAX    = nlq_pkg::LineMax
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  command_i,
  input  logic [7:0]  byte_in_i,
  input  logic        discard_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  status_o,
  output logic [7:0]  byte_out_o,
  output logic        last_o,
  output logic [8:0]  line_length_o,
  output logic        restarted_o
);

  logic [8:0]   read_limit_q;
  logic         op_valid, op_ready, busy;
  nlq_pkg::op_t op;

  assign pready = 1'b1;
  assign prdata = (paddr == 2'd0) ? {23'd0, read_limit_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      read_limit_q <= nlq_pkg::ReadLimitReset;
    end else if (psel && penable && pwrite && paddr == 2'd0) begin
      read_limit_q <= pwdata[8:0];
    end
  end

  nlq_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .command_i, .byte_in_i, .discard_i,
    .op_valid_o(op_valid), .op_ready_i(op_ready), .op_o(op)
  );

  nlq_back #(.QUEUE_LINES(QUEUE_LINES), .LINE_MAX(LINE_MAX)) u_back (
    .clk_i, .rst_ni, .read_limit_i(read_limit_q),
    .op_valid_i(op_valid), .op_ready_o(op_ready), .op_i(op),
    .out_valid_o, .out_ready_i, .status_o, .byte_out_o, .last_o,
    .line_length_o, .restarted_o, .busy_o(busy)
  );

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o) && $stable(byte_out_o))
    else $error("result changed while stalled");
  a_status_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> status_o != 2'd3)
    else $error("bad status");
  a_empty_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == nlq_pkg::StEmpty |-> last_o && byte_out_o == 8'd0)
    else $error("empty line without last");
  a_none_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == nlq_pkg::StNone |-> line_length_o == 9'd0 && !last_o)
    else $error("no-line result carries data");
  a_busy_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |-> !op_ready)
    else $error("back end took op while busy");

endmodule

// ===== hw/rtl/nlq_front.sv =====
// Front end: accepts transactions, drops discarded bytes, classifies the rest.
module nlq_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [1:0]       command_i,
  input  logic [7:0]       byte_in_i,
  input  logic             discard_i,
  output logic             op_valid_o,
  input  logic             op_ready_i,
  output nlq_pkg::op_t     op_o
);

  // Two-entry queue toward the back end.
  nlq_pkg::op_t buf_q [2];
  logic         wp_q, rp_q;
  logic [1:0]   cnt_q;
  nlq_pkg::op_t cls;
  logic         keep, push, pop;

  always_comb begin
    cls.data = byte_in_i;
    keep     = 1'b1;
    cls.op   = nlq_pkg::OpByte;
    unique case (command_i)
      nlq_pkg::CmdRecv: begin
        keep   = !discard_i;
        cls.op = (byte_in_i == nlq_pkg::NewlineByte) ? nlq_pkg::OpEol : nlq_pkg::OpByte;
      end
      nlq_pkg::CmdFetch: cls.op = nlq_pkg::OpFetch;
      nlq_pkg::CmdClear: cls.op = nlq_pkg::OpClear;
      default:           cls.op = nlq_pkg::OpFlush;
    endcase
  end

  assign in_ready_o = (cnt_q != 2'd2);
  assign push       = in_valid_i && in_ready_o && keep;
  assign op_valid_o = (cnt_q != 2'd0);
  assign pop        = op_valid_o && op_ready_i;
  assign op_o       = buf_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      buf_q[wp_q] <= cls;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wp_q <= !wp_q;
      if (pop)  rp_q <= !rp_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

// ===== hw/rtl/nlq_back.sv =====
// Back end: partial-line buffer, line ring with a spare slot, fetch logic.
module nlq_back #(
  parameter int unsigned QUEUE_LINES = nlq_pkg::QueueLines,
  parameter int unsigned LINE_MAX    = nlq_pkg::LineMax
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic [8:0]   read_limit_i,
  input  logic         op_valid_i,
  output logic         op_ready_o,
  input  nlq_pkg::op_t op_i,
  output logic         out_valid_o,
  input  logic         out_ready_i,
  output logic [1:0]   status_o,
  output logic [7:0]   byte_out_o,
  output logic         last_o,
  output logic [8:0]   line_length_o,
  output logic         restarted_o,
  output logic         busy_o
);

  // One physical slot more than the ring holds: the partial line is always
  // built in the free slot just past the newest line.
  localparam int unsigned NS = QUEUE_LINES + 1;
  localparam int unsigned SW = $clog2(NS);
  localparam int unsigned CW = $clog2(LINE_MAX + 1);
  localparam int unsigned PW = $clog2(LINE_MAX);
  localparam int unsigned TW = $clog2(QUEUE_LINES + 1);
  localparam int unsigned AW = SW + PW;
  localparam int unsigned MD = NS << PW;

  localparam logic [2:0] SIdle  = 3'd0;
  localparam logic [2:0] SRead  = 3'd1;
  localparam logic [2:0] SData  = 3'd2;

  logic [7:0]    mem [MD];
  logic [CW-1:0] len_mem [NS];

  logic [2:0]    st_q;
  logic [CW-1:0] pcnt_q;
  logic [SW-1:0] oldest_q;
  logic [TW-1:0] total_q;
  logic [CW-1:0] cur_q;
  logic          rp_q;
  logic [CW-1:0] len_q;
  logic [7:0]    rd_q;
  logic [1:0]    status_q;
  logic [7:0]    byte_q;
  logic          last_q;
  logic [8:0]    llen_q;
  logic          rs_q;
  logic          ov_q;

  logic [SW-1:0] tail;
  logic [CW:0]   lim, trunc_w;
  logic [CW-1:0] trunc;
  logic          full;

  // Ring index arithmetic without division: values stay below twice the size.
  function automatic logic [SW-1:0] wrap(input logic [SW:0] v);
    if (v >= (SW+1)'(NS)) wrap = SW'(v - (SW+1)'(NS));
    else wrap = SW'(v);
  endfunction

  // Tail only moves when the partial line is emptied (end of line or flush).
  assign full  = (total_q >= TW'(QUEUE_LINES));
  assign tail  = wrap((SW+1)'(oldest_q) + (SW+1)'(total_q));
  assign lim   = (read_limit_i == 9'd0) ? '0 : (CW+1)'(read_limit_i - 9'd1);
  assign trunc_w = ((CW+1)'(len_q) < lim) ? (CW+1)'(len_q) : lim;
  assign trunc = CW'(trunc_w);

  assign op_ready_o  = (st_q == SIdle) && !ov_q;
  assign out_valid_o = ov_q;
  assign status_o    = status_q;
  assign byte_out_o  = byte_q;
  assign last_o      = last_q;
  assign line_length_o = llen_q;
  assign restarted_o = rs_q;
  assign busy_o      = (st_q != SIdle) || ov_q;

  logic do_op;
  assign do_op = op_valid_i && op_ready_o;

  always_ff @(posedge clk_i) begin
    if (do_op && op_i.op == nlq_pkg::OpByte && pcnt_q < CW'(LINE_MAX)) begin
      mem[{tail, PW'(pcnt_q)}] <= op_i.data;
    end
    if (do_op && op_i.op == nlq_pkg::OpEol) begin
      len_mem[tail] <= pcnt_q;
    end
    rd_q  <= mem[{oldest_q, PW'(cur_q)}];
    len_q <= len_mem[oldest_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q     <= SIdle;
      pcnt_q   <= '0;
      oldest_q <= '0;
      total_q  <= '0;
      cur_q    <= '0;
      rp_q     <= 1'b0;
      ov_q     <= 1'b0;
      rs_q     <= 1'b0;
      status_q <= nlq_pkg::StNone;
      byte_q   <= '0;
      last_q   <= 1'b0;
      llen_q   <= '0;
    end else begin
      if (ov_q && out_ready_i) ov_q <= 1'b0;
      unique case (st_q)
        SIdle: if (do_op) begin
          unique case (op_i.op)
            nlq_pkg::OpByte: begin
              if (pcnt_q < CW'(LINE_MAX)) pcnt_q <= pcnt_q + CW'(1);
              else pcnt_q <= '0;
            end
            nlq_pkg::OpEol: begin
              if (full) begin
                if (cur_q != '0) begin
                  cur_q <= '0;
                  rp_q  <= 1'b1;
                end
                // Oldest line is dropped; its slot becomes the next free one.
                oldest_q <= wrap((SW+1)'(oldest_q) + (SW+1)'(1));
              end else begin
                total_q <= total_q + TW'(1);
              end
              pcnt_q <= '0;
            end
            nlq_pkg::OpFetch: begin
              rs_q <= rp_q;
              rp_q <= 1'b0;
              if (total_q == '0) begin
                status_q <= nlq_pkg::StNone;
                byte_q   <= '0;
                last_q   <= 1'b0;
                llen_q   <= '0;
                ov_q     <= 1'b1;
              end else begin
                st_q <= SRead;
              end
            end
            nlq_pkg::OpClear: pcnt_q <= '0;
            nlq_pkg::OpFlush: begin
              pcnt_q   <= '0;
              total_q  <= '0;
              oldest_q <= '0;
              cur_q    <= '0;
              rp_q     <= 1'b0;
            end
            default: ;
          endcase
        end
        SRead: st_q <= SData;
        SData: begin
          st_q   <= SIdle;
          ov_q   <= 1'b1;
          llen_q <= 9'(trunc);
          if (cur_q >= trunc) begin
            status_q <= nlq_pkg::StEmpty;
            byte_q   <= '0;
            last_q   <= 1'b1;
            cur_q    <= '0;
            oldest_q <= wrap((SW+1)'(oldest_q) + (SW+1)'(1));
            total_q  <= total_q - TW'(1);
          end else begin
            status_q <= nlq_pkg::StData;
            byte_q   <= rd_q;
            if (cur_q + CW'(1) >= trunc) begin
              last_q   <= 1'b1;
              cur_q    <= '0;
              oldest_q <= wrap((SW+1)'(oldest_q) + (SW+1)'(1));
              total_q  <= total_q - TW'(1);
            end else begin
              last_q <= 1'b0;
              cur_q  <= cur_q + CW'(1);
            end
          end
        end
        default: st_q <= SIdle;
      endcase
    end
  end

endmodule

// ===== bench/nlq_line_checker.sv =====
// Checker for the newline line queue: tracks lines, predicts fetch results, compares.
module nlq_line_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  input  logic        in_valid_i,
  input  logic        in_ready_o,
  input  logic [1:0]  command_i,
  input  logic [7:0]  byte_in_i,
  input  logic        discard_i,
  input  logic        out_valid_o,
  input  logic        out_ready_i,
  input  logic [1:0]  status_o,
  input  logic [7:0]  byte_out_o,
  input  logic        last_o,
  input  logic [8:0]  line_length_o,
  input  logic        restarted_o,
  output int          fail_count_o,
  output int          pending_o
);

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] data;
    logic       last;
    logic [8:0] len;
    logic       restarted;
  } fetch_result_t;

  fetch_result_t fetch_q[$];

  logic [7:0] part_buf[nlq_pkg::LineMax];
  logic [7:0] ring_buf[nlq_pkg::QueueLines][nlq_pkg::LineMax];
  int         ring_len[nlq_pkg::QueueLines];
  int         part_cnt, head, line_cnt, cursor, read_limit;
  logic       restart_flag;

  function automatic int slot_after(int s);
    return (s + 1) % nlq_pkg::QueueLines;
  endfunction

  task automatic enqueue_line();
    int tail;
    if (line_cnt >= nlq_pkg::QueueLines) begin
      // ring full: oldest line goes, a partial read restarts
      if (cursor != 0) begin
        cursor = 0;
        restart_flag = 1'b1;
      end
      head = slot_after(head);
      line_cnt--;
    end
    tail = (head + line_cnt) % nlq_pkg::QueueLines;
    for (int i = 0; i < part_cnt; i++) ring_buf[tail][i] = part_buf[i];
    ring_len[tail] = part_cnt;
    line_cnt++;
    part_cnt = 0;
  endtask

  task automatic predict_fetch();
    fetch_result_t r;
    int lim, trunc;
    r = '0;
    r.restarted = restart_flag;
    restart_flag = 1'b0;
    if (line_cnt != 0) begin
      lim = (read_limit == 0) ? 0 : read_limit - 1;
      trunc = (ring_len[head] < lim) ? ring_len[head] : lim;
      r.len = trunc[8:0];
      if (cursor >= trunc) begin
        r.status = nlq_pkg::StEmpty;
        r.last = 1'b1;
        cursor = 0;
        head = slot_after(head);
        line_cnt--;
      end else begin
        r.status = nlq_pkg::StData;
        r.data = ring_buf[head][cursor];
        cursor++;
        if (cursor >= trunc) begin
          r.last = 1'b1;
          cursor = 0;
          head = slot_after(head);
          line_cnt--;
        end
      end
    end
    fetch_q.push_back(r);
  endtask

  task automatic apply_transaction(logic [1:0] cmd, logic [7:0] b, logic d);
    case (cmd)
      nlq_pkg::CmdRecv: begin
        if (!d) begin
          if (b == nlq_pkg::NewlineByte) enqueue_line();
          else if (part_cnt < nlq_pkg::LineMax) begin
            part_buf[part_cnt] = b;
            part_cnt++;
          end else part_cnt = 0;  // overlong line thrown away with this byte
        end
      end
      nlq_pkg::CmdFetch: predict_fetch();
      nlq_pkg::CmdClear: part_cnt = 0;
      default: begin
        part_cnt = 0;
        line_cnt = 0;
        head = 0;
        cursor = 0;
        restart_flag = 1'b0;
      end
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    fetch_result_t exp_r, got_r;
    if (!rst_ni) begin
      part_cnt = 0;
      head = 0;
      line_cnt = 0;
      cursor = 0;
      restart_flag = 1'b0;
      read_limit = nlq_pkg::ReadLimitReset;
      fetch_q.delete();
      fail_count_o = 0;
    end else begin
      if (psel && penable && pwrite && pready && paddr == 2'd0)
        read_limit = pwdata[8:0];
      if (in_valid_i && in_ready_o) apply_transaction(command_i, byte_in_i, discard_i);
      if (out_valid_o && out_ready_i) begin
        got_r = '{status_o, byte_out_o, last_o, line_length_o, restarted_o};
        if (fetch_q.size() == 0) begin
          fail_count_o++;
          if (fail_count_o <= 10) $display("unexpected result transaction: %p", got_r);
        end else begin
          exp_r = fetch_q.pop_front();
          if (got_r !== exp_r) begin
            fail_count_o++;
            if (fail_count_o <= 10)
              $display("result mismatch: expected %p, got %p", exp_r, got_r);
          end
        end
      end
    end
    pending_o = fetch_q.size();
  end

endmodule

// ===== bench/tb.sv =====
// Testbench top for the newline line queue: stimulus, register writes and verdict.
module tb;

  localparam int CycleLimit = 600000;

  logic        clk_i, rst_ni;
  logic        psel, penable, pwrite;
  logic [1:0]  paddr;
  logic [31:0] pwdata, prdata;
  logic        pready;
  logic        in_valid_i, in_ready_o;
  logic [1:0]  command_i;
  logic [7:0]  byte_in_i;
  logic        discard_i;
  logic        out_valid_o, out_ready_i;
  logic [1:0]  status_o;
  logic [7:0]  byte_out_o;
  logic        last_o;
  logic [8:0]  line_length_o;
  logic        restarted_o;
  int          fail_count, pending;
  int          cycles = 0;
  int          sink_wait;
  bit          gaps_on;

  newline_line_queue_unit dut (.*);

  nlq_line_checker chk (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
    .in_valid_i, .in_ready_o, .command_i, .byte_in_i, .discard_i,
    .out_valid_o, .out_ready_i, .status_o, .byte_out_o, .last_o,
    .line_length_o, .restarted_o,
    .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("tb failed");
      $finish;
    end
  end

  // result side stalls: fresh draw after each accepted transaction
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      sink_wait = 0;
    end else begin
      if (out_valid_o && out_ready_i) sink_wait = gaps_on ? $urandom_range(0, 3) : 0;
      if (sink_wait > 0) begin
        sink_wait--;
        out_ready_i <= 1'b0;
      end else out_ready_i <= 1'b1;
    end
  end

  task automatic send(logic [1:0] cmd, logic [7:0] b, logic d);
    int gap;
    gap = gaps_on ? $urandom_range(0, 3) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    command_i <= cmd;
    byte_in_i <= b;
    discard_i <= d;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  task automatic send_char(logic d);
    logic [7:0] b;
    b = 8'($urandom_range(0, 255));
    if (b == nlq_pkg::NewlineByte) b = 8'h0b;
    send(nlq_pkg::CmdRecv, b, d);
  endtask

  // drain all results, let the back end settle, then program the limit
  task automatic set_read_limit(int unsigned v);
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= 2'd0;
    pwdata <= v;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic random_phase(int mode, int n);
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 999);
      case (mode)
        0: begin  // mixed traffic
          if (r < 520) send_char($urandom_range(0, 19) == 0);
          else if (r < 640) send(nlq_pkg::CmdRecv, nlq_pkg::NewlineByte, 1'b0);
          else if (r < 880) send(nlq_pkg::CmdFetch, 8'($urandom), 1'($urandom));
          else if (r < 920) send(nlq_pkg::CmdClear, 8'($urandom), 1'($urandom));
          else if (r < 940) send(nlq_pkg::CmdFlush, 8'($urandom), 1'($urandom));
          else send(nlq_pkg::CmdRecv, 8'($urandom), 1'($urandom));
        end
        1: begin  // fill the ring past capacity with short lines
          if (r < 650) send_char(1'b0);
          else if (r < 930) send(nlq_pkg::CmdRecv, nlq_pkg::NewlineByte, 1'b0);
          else if (r < 980) send(nlq_pkg::CmdFetch, 8'($urandom), 1'b0);
          else send(nlq_pkg::CmdRecv, nlq_pkg::NewlineByte, 1'b1);
        end
        2: begin  // drain
          if (r < 850) send(nlq_pkg::CmdFetch, 8'($urandom), 1'($urandom));
          else if (r < 950) send_char(1'b0);
          else send(nlq_pkg::CmdRecv, nlq_pkg::NewlineByte, 1'b0);
        end
        default: begin  // long lines, some past the line limit
          if (r < 4) send(nlq_pkg::CmdRecv, nlq_pkg::NewlineByte, 1'b0);
          else if (r < 30) send(nlq_pkg::CmdFetch, 8'($urandom), 1'b0);
          else send_char(1'b0);
        end
      endcase
    end
  endtask

  initial begin
    int unsigned lim_list[8];
    lim_list = '{257, 1, 3, 257, 2, 0, 9, 256};
    gaps_on = 1'b1;
    rst_ni = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = 2'd0;
    pwdata = '0;
    in_valid_i = 1'b0;
    command_i = nlq_pkg::CmdRecv;
    byte_in_i = '0;
    discard_i = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty queue, empty line, byte extremes, discard, clear, flush
    send(nlq_pkg::CmdFetch, 8'h00, 1'b0);
    send(nlq_pkg::CmdRecv, nlq_pkg::NewlineByte, 1'b0);
    send(nlq_pkg::CmdFetch, 8'hff, 1'b1);
    send(nlq_pkg::CmdRecv, 8'h00, 1'b0);
    send(nlq_pkg::CmdRecv, 8'hff, 1'b0);
    send(nlq_pkg::CmdRecv, 8'h55, 1'b1);
    send(nlq_pkg::CmdRecv, nlq_pkg::NewlineByte, 1'b1);
    send(nlq_pkg::CmdRecv, 8'haa, 1'b0);
    send(nlq_pkg::CmdRecv, nlq_pkg::NewlineByte, 1'b0);
    send(nlq_pkg::CmdFetch, 8'h00, 1'b0);
    send(nlq_pkg::CmdFetch, 8'h00, 1'b0);
    send(nlq_pkg::CmdRecv, 8'h12, 1'b0);
    send(nlq_pkg::CmdClear, 8'hff, 1'b1);
    send(nlq_pkg::CmdRecv, nlq_pkg::NewlineByte, 1'b0);
    send(nlq_pkg::CmdFetch, 8'h00, 1'b0);
    send(nlq_pkg::CmdFetch, 8'h00, 1'b0);
    send(nlq_pkg::CmdRecv, 8'h34, 1'b0);
    send(nlq_pkg::CmdRecv, nlq_pkg::NewlineByte, 1'b0);
    send(nlq_pkg::CmdRecv, 8'h56, 1'b0);
    send(nlq_pkg::CmdFlush, 8'h00, 1'b1);
    send(nlq_pkg::CmdFetch, 8'h00, 1'b0);
    send(nlq_pkg::CmdRecv, 8'h77, 1'b0);
    send(nlq_pkg::CmdRecv, nlq_pkg::NewlineByte, 1'b0);
    send(nlq_pkg::CmdFetch, 8'h00, 1'b0);

    for (int p = 0; p < 12; p++) begin
      set_read_limit(p < 8 ? lim_list[p] : $urandom_range(1, 257));
      gaps_on = (p % 3 != 1);
      random_phase(p % 4, (p % 4 == 3) ? 200 : 130);
      // leave a line half read so the next limit can fall below the cursor
      send(nlq_pkg::CmdFetch, 8'h00, 1'b0);
    end
    set_read_limit(257);
    random_phase(0, 40);

    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (fail_count == 0) $display("tb passed");
    else $display("tb failed");
    $finish;
  end

endmodule
